### design/osa_pkg.sv
// shared constants and codes for the owned slot allocator
package osa_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam int OWNER_BITS_DEF = 22;

	localparam int OPCODE_W = 2;
	localparam int OWNER_ID_W = 22;
	localparam int SLOT_IDX_W = 10;
	localparam int STATUS_W = 3;
	localparam int CFG_W = 7;
	localparam int CMP_W = SLOT_IDX_W + 1;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

	localparam logic [OPCODE_W-1:0] OP_ACQ_ONE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_REL_ONE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_ACQ_RANGE = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_REL_ALL = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DENIED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BUSY = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PASS1 = 4'b0010,
		S_PASS2 = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

endpackage

### design/osa_cell.sv
// one ring cell: busy bit and owner tag of one slot, handed on when the ring turns
module osa_cell import osa_pkg::*; #(
	parameter int OWNER_BITS = OWNER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  logic                  busy_in,
	input  logic [OWNER_BITS-1:0] owner_in,
	output logic                  busy_q,
	output logic [OWNER_BITS-1:0] owner_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			owner_q <= '0;
		end else if (shift) begin
			busy_q  <= busy_in;
			owner_q <= owner_in;
		end
	end

endmodule

### design/osa_ctrl.sv
// request sequencer: walks the ring one slot per cycle and edits the head slot
module osa_ctrl import osa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int OWNER_BITS = OWNER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [OWNER_ID_W-1:0] owner_id,
	input  logic [SLOT_IDX_W-1:0] slot_sel,
	input  logic [SLOT_IDX_W-1:0] range_end,
	input  logic                  range_contiguous,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_IDX_W-1:0] granted_slot,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,
	output logic                  shift,
	input  logic                  head_busy,
	input  logic [OWNER_BITS-1:0] head_owner,
	output logic                  wb_busy,
	output logic [OWNER_BITS-1:0] wb_owner
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	state_t                  state_q;
	logic [CFG_W-1:0]        slots_q;
	logic [OPCODE_W-1:0]     op_q;
	logic [OWNER_BITS-1:0]   who_q;
	logic [SLOT_IDX_W-1:0]   first_q;
	logic [SLOT_IDX_W-1:0]   last_q;
	logic [IDX_W-1:0]        cnt_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [SLOT_IDX_W-1:0]   res_slot_q;
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [SLOT_IDX_W-1:0]   granted_q;

	logic [CMP_W-1:0]        n_x;
	logic [CMP_W-1:0]        cnt_x;
	logic [CMP_W-1:0]        first_x;
	logic [CMP_W-1:0]        last_x;
	logic [CMP_W-1:0]        first_in;
	logic [CMP_W-1:0]        last_in;
	logic [OWNER_BITS-1:0]   who_in;
	logic                    accept;
	logic                    end_pass;
	logic                    in_n;
	logic                    in_span;
	logic                    at_first;
	logic                    owned;
	logic                    take_c;
	logic                    clear_rel;
	logic                    deny_c;
	logic                    hit_c;
	logic                    set_rng;
	logic                    clear_all;
	logic                    bad_args;
	logic [STATUS_W-1:0]     init_status;

	assign in_ready     = (state_q == S_IDLE);
	assign accept       = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign shift        = (state_q == S_PASS1) || (state_q == S_PASS2);
	assign end_pass     = (cnt_q == LAST_IDX);

	// effective slot count saturates at the built size
	assign n_x = (CMP_W'(slots_q) > CMP_W'(SLOT_COUNT)) ? CMP_W'(SLOT_COUNT)
		: CMP_W'(slots_q);
	assign cnt_x    = CMP_W'(cnt_q);
	assign first_x  = CMP_W'(first_q);
	assign last_x   = CMP_W'(last_q);
	assign first_in = CMP_W'(slot_sel);
	assign last_in  = CMP_W'(range_end);
	assign who_in   = OWNER_BITS'(32'(owner_id));

	assign in_n     = cnt_x < n_x;
	assign in_span  = (cnt_x >= first_x) && (cnt_x <= last_x);
	assign at_first = (cnt_x == first_x);
	assign owned    = head_busy && (head_owner == who_q);

	assign take_c    = (state_q == S_PASS1) && (op_q == OP_ACQ_ONE)
		&& (res_status_q == ST_NOSPACE) && in_n && !head_busy;
	assign clear_rel = (state_q == S_PASS1) && (op_q == OP_REL_ONE) && at_first && owned;
	assign deny_c    = (state_q == S_PASS1) && (op_q == OP_REL_ONE) && at_first && !owned;
	assign hit_c     = (state_q == S_PASS1) && (op_q == OP_ACQ_RANGE) && in_span && head_busy;
	assign set_rng   = (state_q == S_PASS2) && in_span;
	assign clear_all = (state_q == S_PASS1) && (op_q == OP_REL_ALL) && in_n && owned;

	always_comb begin
		wb_busy  = head_busy;
		wb_owner = head_owner;
		if (take_c || set_rng) begin
			wb_busy  = 1'b1;
			wb_owner = who_q;
		end else if (clear_rel || clear_all) begin
			wb_busy  = 1'b0;
			wb_owner = '0;
		end
	end

	// argument checks and starting status of a new word
	always_comb begin
		bad_args    = 1'b0;
		init_status = ST_OK;
		unique case (opcode)
			OP_ACQ_ONE: init_status = ST_NOSPACE;
			OP_REL_ONE: bad_args = (first_in >= n_x);
			OP_ACQ_RANGE: bad_args = !range_contiguous || (first_in >= n_x)
				|| (last_in >= n_x) || (first_in > last_in);
			default: init_status = ST_OK;
		endcase
		if (bad_args) begin
			init_status = ST_INVALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slots_q      <= CFG_RESET;
			cnt_q        <= '0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			// in the done state the output register is reloaded below instead
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			if (shift) begin
				cnt_q <= end_pass ? '0 : cnt_q + IDX_W'(1);
			end
			if (take_c) begin
				res_status_q <= ST_OK;
				res_slot_q   <= SLOT_IDX_W'(cnt_q);
			end
			if (deny_c) begin
				res_status_q <= ST_DENIED;
			end
			if (hit_c) begin
				res_status_q <= ST_BUSY;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_status_q <= init_status;
						res_slot_q   <= '0;
						cnt_q        <= '0;
						state_q      <= bad_args ? S_DONE : S_PASS1;
					end
				end
				S_PASS1: begin
					if (end_pass) begin
						state_q <= (op_q == OP_ACQ_RANGE && !hit_c && res_status_q == ST_OK)
							? S_PASS2 : S_DONE;
					end
				end
				S_PASS2: begin
					if (end_pass) begin
						res_slot_q <= first_q;
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			who_q   <= who_in;
			first_q <= slot_sel;
			last_q  <= range_end;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			status_q  <= res_status_q;
			granted_q <= res_slot_q;
		end
	end

endmodule

### design/owned_slot_allocator_unit.sv
// owned slot allocator: ring of slot cells turned by the request sequencer
// bad arguments go straight to the done state; acquire-one, release-one and release-all
// take one turn of the ring; acquire-range takes a check turn, then a take turn only
// if no slot in its range is busy; one word at a time; each full turn of the slot ring
// visits every slot once at its head; done holds while an earlier result is not taken
// reset: all slots free with owner tag zero, slot count register at 64
module owned_slot_allocator_unit import osa_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int OWNER_BITS = OWNER_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OPCODE_W-1:0]   opcode,
	input  logic [OWNER_ID_W-1:0] owner_id,
	input  logic [SLOT_IDX_W-1:0] slot_sel,
	input  logic [SLOT_IDX_W-1:0] range_end,
	input  logic                  range_contiguous,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_IDX_W-1:0] granted_slot,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	logic                  shift;
	logic                  wb_busy;
	logic [OWNER_BITS-1:0] wb_owner;
	logic                  ring_busy [SLOT_COUNT];
	logic [OWNER_BITS-1:0] ring_owner [SLOT_COUNT];

	osa_ctrl #(
		.SLOT_COUNT(SLOT_COUNT),
		.OWNER_BITS(OWNER_BITS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.owner_id         (owner_id),
		.slot_sel         (slot_sel),
		.range_end        (range_end),
		.range_contiguous (range_contiguous),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.granted_slot     (granted_slot),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.shift            (shift),
		.head_busy        (ring_busy[0]),
		.head_owner       (ring_owner[0]),
		.wb_busy          (wb_busy),
		.wb_owner         (wb_owner)
	);

	// cell 0 is the head; the edited head slot re-enters at the tail
	for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_ring
		logic                  nxt_busy;
		logic [OWNER_BITS-1:0] nxt_owner;
		if (k == SLOT_COUNT - 1) begin : g_tail
			assign nxt_busy  = wb_busy;
			assign nxt_owner = wb_owner;
		end else begin : g_mid
			assign nxt_busy  = ring_busy[k+1];
			assign nxt_owner = ring_owner[k+1];
		end
		osa_cell #(
			.OWNER_BITS(OWNER_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (shift),
			.busy_in  (nxt_busy),
			.owner_in (nxt_owner),
			.busy_q   (ring_busy[k]),
			.owner_q  (ring_owner[k])
		);
	end

endmodule
